>>> rtl/mutation_pair_cooccurrence_chisq_defines.svh
// Assertion macros shared by the co-occurrence counter RTL
`ifndef MUTATION_PAIR_COOCCURRENCE_CHISQ_DEFINES_SVH
`define MUTATION_PAIR_COOCCURRENCE_CHISQ_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define MPCC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define MPCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/mpcc_pkg.sv
// Package: shared types and constants of the co-occurrence counter
`default_nettype none
package mpcc_pkg;

    // Field widths fixed by the channel definitions
    localparam int SYM_BITS      = 8;
    localparam int MUTS_BITS     = 16;
    localparam int QIDX_BITS     = 8;
    localparam int OUT_BITS      = 20;
    localparam int SEQ_LEN_BITS  = 9;
    localparam int MAX_READ_BITS = 20;
    localparam int THR_BITS      = 8;
    localparam int SEEN_BITS     = 21;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEQ_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_READS     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHI_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [SEQ_LEN_BITS-1:0]  SEQ_LENGTH_RST    = 9'd256;
    localparam logic [MAX_READ_BITS-1:0] MAX_READS_RST     = 20'hFFFFF;
    localparam logic [THR_BITS-1:0]      CHI_THRESHOLD_RST = 8'd20;

    // Mutated base codes
    localparam logic [SYM_BITS-1:0] SYM_A = 8'h41;
    localparam logic [SYM_BITS-1:0] SYM_T = 8'h54;
    localparam logic [SYM_BITS-1:0] SYM_C = 8'h43;
    localparam logic [SYM_BITS-1:0] SYM_G = 8'h47;

    // Five percent cutoff: 20 * mutations must stay below the length
    localparam logic [SEEN_BITS-1:0] MUT_RATIO = 21'd20;

    // Function codes
    localparam logic FUNC_SYMBOL = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Main controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_QWAIT,
        ST_CHI,
        ST_HOLD
    } mpcc_state_t;

    // Chi-square sequencer states
    typedef enum logic [3:0] {
        CH_IDLE,
        CH_AD,
        CH_BC,
        CH_DD,
        CH_DF,
        CH_SQ,
        CH_LHS,
        CH_P1,
        CH_P2,
        CH_DIM,
        CH_RHS
    } mpcc_chi_state_t;

    // Test outcome flags
    typedef struct packed {
        logic significant;
        logic zero_margin;
    } mpcc_flags_t;

endpackage
`default_nettype wire

>>> rtl/mpcc_if.sv
// Interfaces: item, result and configuration channels
`default_nettype none
interface mpcc_item_if;
    import mpcc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [SYM_BITS-1:0]  symbol;
    logic [MUTS_BITS-1:0] read_mutations;
    logic                 last_symbol;
    logic [QIDX_BITS-1:0] query_first;
    logic [QIDX_BITS-1:0] query_second;
    modport source (output valid, func, symbol, read_mutations, last_symbol,
                    query_first, query_second, input ready);
    modport sink (input valid, func, symbol, read_mutations, last_symbol,
                  query_first, query_second, output ready);
endinterface

interface mpcc_result_if;
    import mpcc_pkg::*;
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] count_neither;
    logic [OUT_BITS-1:0] count_first_only;
    logic [OUT_BITS-1:0] count_second_only;
    logic [OUT_BITS-1:0] count_both;
    logic                significant;
    logic                zero_margin;
    logic                bad_pair;
    modport source (output valid, count_neither, count_first_only, count_second_only,
                    count_both, significant, zero_margin, bad_pair, input ready);
    modport sink (input valid, count_neither, count_first_only, count_second_only,
                  count_both, significant, zero_margin, bad_pair, output ready);
endinterface

interface mpcc_cfg_if;
    import mpcc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/mpcc_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module mpcc_ram #(
    parameter int WIDTH     = 80,
    parameter int DEPTH     = 32640,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/mpcc_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module mpcc_mul #(
    parameter int A_BITS = 114,
    parameter int B_BITS = 42
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [A_BITS-1:0] op_a,
    input  wire logic [B_BITS-1:0] op_b,
    output logic                   done,
    output logic      [A_BITS-1:0] product
);

    localparam int CW = $clog2(B_BITS + 1);

    logic [A_BITS-1:0] a_reg, a_next;
    logic [B_BITS-1:0] b_reg, b_next;
    logic [A_BITS-1:0] acc_reg, acc_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // One partial product added per cycle
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            cnt_next  = CW'(B_BITS);
            busy_next = 1'b1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

>>> rtl/mpcc_chisq.sv
// Yates chi-square test of one 2x2 table, sequenced over the shared multiplier
`default_nettype none
module mpcc_chisq #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [COUNT_BITS-1:0]    cnt_a,
    input  wire logic [COUNT_BITS-1:0]    cnt_b,
    input  wire logic [COUNT_BITS-1:0]    cnt_c,
    input  wire logic [COUNT_BITS-1:0]    cnt_d,
    input  wire logic [mpcc_pkg::THR_BITS-1:0] threshold,
    output logic                          done,
    output mpcc_pkg::mpcc_flags_t         flags
);
    import mpcc_pkg::*;

    localparam int CB  = COUNT_BITS;
    localparam int BW  = 2 * CB + 2;
    localparam int PWD = 5 * CB + 14;

    mpcc_chi_state_t   state_reg, state_next;
    logic              issued_reg, issued_next;
    logic              done_reg, done_next;
    mpcc_flags_t       flags_reg, flags_next;

    logic [CB-1:0]       a_reg, b_reg, c_reg, d_reg;
    logic [CB-1:0]       a_next, b_next, c_next, d_next;
    logic [THR_BITS-1:0] thr_reg, thr_next;
    logic [CB+1:0]       n_reg, n_next;
    logic [2*CB-1:0]     ad_reg, ad_next, bc_reg, bc_next;
    logic [2*CB:0]       dd2_reg, dd2_next;
    logic [BW-1:0]       df_reg, df_next;
    logic [PWD-1:0]      sq_reg, sq_next, lhs_reg, lhs_next, dim_reg, dim_next;
    logic [BW-1:0]       p1_reg, p1_next, p2_reg, p2_next;

    logic [CB:0]         m1, m2, m3, m4;
    logic [2*CB-1:0]     dd;
    logic                mul_start, mul_done;
    logic [PWD-1:0]      mul_a, mul_product;
    logic [BW-1:0]       mul_b;

    mpcc_mul #(
        .A_BITS (PWD),
        .B_BITS (BW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // Marginal sums
    assign m1 = {1'b0, a_reg} + {1'b0, b_reg};
    assign m2 = {1'b0, c_reg} + {1'b0, d_reg};
    assign m3 = {1'b0, a_reg} + {1'b0, c_reg};
    assign m4 = {1'b0, b_reg} + {1'b0, d_reg};
    assign dd = (ad_reg >= bc_reg) ? (ad_reg - bc_reg) : (bc_reg - ad_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CH_IDLE;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
            flags_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
            flags_reg  <= flags_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        thr_reg <= thr_next;
        n_reg   <= n_next;
        ad_reg  <= ad_next;
        bc_reg  <= bc_next;
        dd2_reg <= dd2_next;
        df_reg  <= df_next;
        sq_reg  <= sq_next;
        lhs_reg <= lhs_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        dim_reg <= dim_next;
    end

    // Sequencer: one multiply per state except CH_DD and CH_DF, issued once and awaited
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        done_next   = 1'b0;
        flags_next  = flags_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        thr_next    = thr_reg;
        n_next      = n_reg;
        ad_next     = ad_reg;
        bc_next     = bc_reg;
        dd2_next    = dd2_reg;
        df_next     = df_reg;
        sq_next     = sq_reg;
        lhs_next    = lhs_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        dim_next    = dim_reg;
        mul_a       = '0;
        mul_b       = '0;
        mul_start   = 1'b0;

        case (state_reg)
            CH_IDLE:
            begin
                if (start)
                begin
                    a_next   = cnt_a;
                    b_next   = cnt_b;
                    c_next   = cnt_c;
                    d_next   = cnt_d;
                    thr_next = threshold;
                    n_next   = (CB+2)'(cnt_a) + (CB+2)'(cnt_b)
                             + (CB+2)'(cnt_c) + (CB+2)'(cnt_d);
                    // Any empty margin: no test
                    if ((cnt_a == '0 && cnt_b == '0) || (cnt_c == '0 && cnt_d == '0) ||
                        (cnt_a == '0 && cnt_c == '0) || (cnt_b == '0 && cnt_d == '0))
                    begin
                        flags_next.significant = 1'b0;
                        flags_next.zero_margin = 1'b1;
                        done_next              = 1'b1;
                    end
                    else
                    begin
                        issued_next = 1'b0;
                        state_next  = CH_AD;
                    end
                end
            end
            CH_AD:
            begin
                mul_a = PWD'(a_reg);
                mul_b = BW'(d_reg);
            end
            CH_BC:
            begin
                mul_a = PWD'(b_reg);
                mul_b = BW'(c_reg);
            end
            CH_DD:
            begin
                dd2_next   = {dd, 1'b0};
                state_next = CH_DF;
            end
            CH_DF:
            begin
                if (dd2_reg >= (2*CB+1)'(n_reg))
                begin
                    df_next = BW'(dd2_reg - (2*CB+1)'(n_reg));
                end
                else
                begin
                    df_next = BW'((2*CB+1)'(n_reg) - dd2_reg);
                end
                issued_next = 1'b0;
                state_next  = CH_SQ;
            end
            CH_SQ:
            begin
                mul_a = PWD'(df_reg);
                mul_b = df_reg;
            end
            CH_LHS:
            begin
                mul_a = sq_reg;
                mul_b = BW'(n_reg);
            end
            CH_P1:
            begin
                mul_a = PWD'(m1);
                mul_b = BW'(m2);
            end
            CH_P2:
            begin
                mul_a = PWD'(m3);
                mul_b = BW'(m4);
            end
            CH_DIM:
            begin
                mul_a = PWD'(p1_reg);
                mul_b = p2_reg;
            end
            CH_RHS:
            begin
                mul_a = dim_reg;
                mul_b = BW'({thr_reg, 2'b00});
            end
            default:
            begin
                state_next = CH_IDLE;
            end
        endcase

        // Multiply issue and completion
        if (state_reg != CH_IDLE && state_reg != CH_DD && state_reg != CH_DF)
        begin
            if (!issued_reg)
            begin
                mul_start   = 1'b1;
                issued_next = 1'b1;
            end
            else if (mul_done)
            begin
                issued_next = 1'b0;
                case (state_reg)
                    CH_AD:
                    begin
                        ad_next    = mul_product[2*CB-1:0];
                        state_next = CH_BC;
                    end
                    CH_BC:
                    begin
                        bc_next    = mul_product[2*CB-1:0];
                        state_next = CH_DD;
                    end
                    CH_SQ:
                    begin
                        sq_next    = mul_product;
                        state_next = CH_LHS;
                    end
                    CH_LHS:
                    begin
                        lhs_next   = mul_product;
                        state_next = CH_P1;
                    end
                    CH_P1:
                    begin
                        p1_next    = mul_product[BW-1:0];
                        state_next = CH_P2;
                    end
                    CH_P2:
                    begin
                        p2_next    = mul_product[BW-1:0];
                        state_next = CH_DIM;
                    end
                    CH_DIM:
                    begin
                        dim_next   = mul_product;
                        state_next = CH_RHS;
                    end
                    CH_RHS:
                    begin
                        flags_next.significant = (lhs_reg > mul_product);
                        flags_next.zero_margin = 1'b0;
                        done_next              = 1'b1;
                        state_next             = CH_IDLE;
                    end
                    default:
                    begin
                        state_next = CH_IDLE;
                    end
                endcase
            end
        end
    end

    assign done  = done_reg;
    assign flags = flags_reg;

endmodule
`default_nettype wire

>>> rtl/mutation_pair_cooccurrence_chisq.sv
// Top level: pairwise mutation co-occurrence counter with chi-square query
//
// Channels: items (symbol or query requests), results (one per query) and
// cfg (register writes, always ready). A request moves on valid && ready.
// Reset clears the control state and then sweeps the pair store to zero,
// one entry per cycle, over all MAX_LEN*(MAX_LEN-1)/2 entries (32640 by default).
// items.ready stays low during that pass; cfg writes are taken throughout.
// A symbol at position p of a used read does p read-modify-writes of the
// pair store, one per cycle through its single read and write ports;
// other symbols make no read-modify-writes. A query reads its entry,
// then runs the chi-square test on a bit-serial multiplier as a chain of
// eight products; an empty margin or a bad pair skips the products.
// The result sits in an output register; while the receiver stalls,
// symbols keep being accepted and a further query waits for the register
// to empty before it completes.
`default_nettype none
module mutation_pair_cooccurrence_chisq #(
    parameter int MAX_LEN    = 256,
    parameter int COUNT_BITS = 20
) (
    input wire logic      clk,
    input wire logic      rst_n,
    mpcc_item_if.sink     items,
    mpcc_result_if.source results,
    mpcc_cfg_if.sink      cfg
);
    import mpcc_pkg::*;

    `include "mutation_pair_cooccurrence_chisq_defines.svh"

    localparam int CB  = COUNT_BITS;
    localparam int NP  = MAX_LEN * (MAX_LEN - 1) / 2;
    localparam int AW  = (NP > 1) ? $clog2(NP) : 1;
    localparam int PW  = $clog2(MAX_LEN + 1);
    localparam int LW  = $clog2(MAX_LEN);
    localparam int QW  = 2 * QIDX_BITS + 1;

    mpcc_state_t state_reg, state_next;

    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic [SEQ_LEN_BITS-1:0]  seq_length_reg;
    logic [MAX_READ_BITS-1:0] max_reads_reg;
    logic [THR_BITS-1:0]      chi_threshold_reg;
    logic [PW-1:0]            read_pos_reg, read_pos_next;
    logic [SEEN_BITS-1:0]     reads_seen_reg, reads_seen_next;
    logic [AW-1:0]            base_reg, base_next;
    logic [PW-1:0]            p_reg, p_next;
    logic [PW-1:0]            rd_i_reg, rd_i_next;
    logic                     mut_cur_reg, mut_cur_next;
    logic                     v1_reg, v1_next;
    logic [AW-1:0]            wr_addr_reg, wr_addr_next;
    logic                     in_store_reg, in_store_next;
    logic                     bad_reg, bad_next;
    logic [CB-1:0]            ca_reg, cb_reg, cc_reg, cd_reg;
    logic [CB-1:0]            ca_next, cb_next, cc_next, cd_next;
    mpcc_flags_t              fl_reg, fl_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]      o_a_reg, o_b_reg, o_c_reg, o_d_reg;
    logic [OUT_BITS-1:0]      o_a_next, o_b_next, o_c_next, o_d_next;
    mpcc_flags_t              o_fl_reg, o_fl_next;
    logic                     o_bad_reg, o_bad_next;

    logic                     item_acc;
    logic                     sym_mut, below_lim, read_used;
    logic [2*PW-1:0]          tri_prod;
    logic [QW-1:0]            q_addr;
    logic                     issue;
    logic [1:0]               kind;
    logic [CB-1:0]            cell_val;
    logic [4*CB-1:0]          inc_word;

    logic                     pr_we;
    logic [AW-1:0]            pr_waddr, pr_raddr;
    logic [4*CB-1:0]          pr_wdata, pr_rdata;
    logic                     mb_we;
    logic [LW-1:0]            mb_waddr, mb_raddr;
    logic [0:0]               mb_rdata;

    logic                     chi_start, chi_done;
    mpcc_flags_t              chi_flags;

    // Pair counter store: {both, second only, first only, neither}
    mpcc_ram #(
        .WIDTH (4 * CB),
        .DEPTH (NP),
        .ADDR_BITS (AW)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    // Mutation bits of the current read
    mpcc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LEN),
        .ADDR_BITS (LW)
    ) u_mut_ram (
        .clk   (clk),
        .we    (mb_we),
        .waddr (mb_waddr),
        .wdata (sym_mut),
        .raddr (mb_raddr),
        .rdata (mb_rdata)
    );

    mpcc_chisq #(
        .COUNT_BITS (CB)
    ) u_chisq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (chi_start),
        .cnt_a     (ca_next),
        .cnt_b     (cb_next),
        .cnt_c     (cc_next),
        .cnt_d     (cd_next),
        .threshold (chi_threshold_reg),
        .done      (chi_done),
        .flags     (chi_flags)
    );

    assign item_acc    = items.valid && items.ready;
    assign items.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    // Symbol decode and read qualification
    assign sym_mut   = items.symbol inside {SYM_A, SYM_T, SYM_C, SYM_G};
    assign below_lim = (32'(read_pos_reg) < 32'(seq_length_reg)) &&
                       (32'(read_pos_reg) < 32'(MAX_LEN));
    assign read_used = (reads_seen_reg < SEEN_BITS'(max_reads_reg)) &&
                       (items.read_mutations != '0) &&
                       ((SEEN_BITS'(items.read_mutations) * MUT_RATIO) <
                        SEEN_BITS'(seq_length_reg));

    // Row base p*(p-1)/2 and query entry address
    assign tri_prod = (2*PW)'(read_pos_reg) * (2*PW)'(read_pos_reg - PW'(1));
    assign q_addr   = QW'((QW'(items.query_second) *
                           QW'(items.query_second - QIDX_BITS'(1))) >> 1)
                    + QW'(items.query_first);

    // Saturating increment of the selected counter
    assign issue    = (rd_i_reg < p_reg);
    assign kind     = {mut_cur_reg, mb_rdata[0]};
    assign cell_val = pr_rdata[kind*CB +: CB];
    always_comb
    begin
        inc_word = pr_rdata;
        if (cell_val != '1)
        begin
            inc_word[kind*CB +: CB] = cell_val + CB'(1);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg    <= SEQ_LENGTH_RST;
            max_reads_reg     <= MAX_READS_RST;
            chi_threshold_reg <= CHI_THRESHOLD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_SEQ_LENGTH:    seq_length_reg    <= cfg.data[SEQ_LEN_BITS-1:0];
                CFG_MAX_READS:     max_reads_reg     <= cfg.data[MAX_READ_BITS-1:0];
                CFG_CHI_THRESHOLD: chi_threshold_reg <= cfg.data[THR_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            read_pos_reg   <= '0;
            reads_seen_reg <= '0;
            rd_i_reg       <= '0;
            p_reg          <= '0;
            v1_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            read_pos_reg   <= read_pos_next;
            reads_seen_reg <= reads_seen_next;
            rd_i_reg       <= rd_i_next;
            p_reg          <= p_next;
            v1_reg         <= v1_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        mut_cur_reg  <= mut_cur_next;
        wr_addr_reg  <= wr_addr_next;
        in_store_reg <= in_store_next;
        bad_reg      <= bad_next;
        ca_reg       <= ca_next;
        cb_reg       <= cb_next;
        cc_reg       <= cc_next;
        cd_reg       <= cd_next;
        fl_reg       <= fl_next;
        o_a_reg      <= o_a_next;
        o_b_reg      <= o_b_next;
        o_c_reg      <= o_c_next;
        o_d_reg      <= o_d_next;
        o_fl_reg     <= o_fl_next;
        o_bad_reg    <= o_bad_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        read_pos_next   = read_pos_reg;
        reads_seen_next = reads_seen_reg;
        base_next       = base_reg;
        p_next          = p_reg;
        rd_i_next       = rd_i_reg;
        mut_cur_next    = mut_cur_reg;
        v1_next         = 1'b0;
        wr_addr_next    = wr_addr_reg;
        in_store_next   = in_store_reg;
        bad_next        = bad_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        cc_next         = cc_reg;
        cd_next         = cd_reg;
        fl_next         = fl_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        o_a_next        = o_a_reg;
        o_b_next        = o_b_reg;
        o_c_next        = o_c_reg;
        o_d_next        = o_d_reg;
        o_fl_next       = o_fl_reg;
        o_bad_next      = o_bad_reg;
        chi_start       = 1'b0;
        pr_we           = 1'b0;
        pr_waddr        = wr_addr_reg;
        pr_wdata        = inc_word;
        pr_raddr        = base_reg + AW'(rd_i_reg);
        mb_we           = 1'b0;
        mb_waddr        = read_pos_reg[LW-1:0];
        mb_raddr        = rd_i_reg[LW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                pr_we         = 1'b1;
                pr_waddr      = clr_addr_reg;
                pr_wdata      = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(NP - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                pr_raddr = AW'(q_addr);
                if (item_acc && items.func == FUNC_SYMBOL)
                begin
                    if (below_lim)
                    begin
                        mb_we = 1'b1;
                        if (read_used && read_pos_reg != '0)
                        begin
                            base_next    = AW'(tri_prod >> 1);
                            p_next       = read_pos_reg;
                            rd_i_next    = '0;
                            mut_cur_next = sym_mut;
                            state_next   = ST_SCAN;
                        end
                    end
                    if (items.last_symbol)
                    begin
                        read_pos_next = '0;
                        if (reads_seen_reg != '1)
                        begin
                            reads_seen_next = reads_seen_reg + SEEN_BITS'(1);
                        end
                    end
                    else if (32'(read_pos_reg) < 32'(MAX_LEN))
                    begin
                        read_pos_next = read_pos_reg + PW'(1);
                    end
                end
                else if (item_acc)
                begin
                    in_store_next = (32'(items.query_second) < 32'(MAX_LEN));
                    if (items.query_first >= items.query_second)
                    begin
                        bad_next   = 1'b1;
                        ca_next    = '0;
                        cb_next    = '0;
                        cc_next    = '0;
                        cd_next    = '0;
                        fl_next    = '0;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = ST_QWAIT;
                    end
                end
            end
            ST_SCAN:
            begin
                // Read one entry per cycle, write it back the cycle after
                pr_we = v1_reg;
                if (issue)
                begin
                    rd_i_next    = rd_i_reg + PW'(1);
                    v1_next      = 1'b1;
                    wr_addr_next = pr_raddr;
                end
                else if (!v1_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QWAIT:
            begin
                ca_next    = in_store_reg ? pr_rdata[0*CB +: CB] : '0;
                cb_next    = in_store_reg ? pr_rdata[1*CB +: CB] : '0;
                cc_next    = in_store_reg ? pr_rdata[2*CB +: CB] : '0;
                cd_next    = in_store_reg ? pr_rdata[3*CB +: CB] : '0;
                chi_start  = 1'b1;
                state_next = ST_CHI;
            end
            ST_CHI:
            begin
                if (chi_done)
                begin
                    fl_next    = chi_flags;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    o_a_next       = OUT_BITS'(ca_reg);
                    o_b_next       = OUT_BITS'(cb_reg);
                    o_c_next       = OUT_BITS'(cc_reg);
                    o_d_next       = OUT_BITS'(cd_reg);
                    o_fl_next      = fl_reg;
                    o_bad_next     = bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign results.valid             = out_valid_reg;
    assign results.count_neither     = o_a_reg;
    assign results.count_first_only  = o_b_reg;
    assign results.count_second_only = o_c_reg;
    assign results.count_both        = o_d_reg;
    assign results.significant       = o_fl_reg.significant;
    assign results.zero_margin       = o_fl_reg.zero_margin;
    assign results.bad_pair          = o_bad_reg;

    // Checks
    `MPCC_ASSERT_ALWAYS(a_flags_exclusive,
        !(results.valid && results.significant && results.zero_margin),
        "significant and zero_margin both set")
    `MPCC_ASSERT_IMP(a_bad_pair_zero, results.valid && results.bad_pair,
        results.count_both == '0 && results.count_neither == '0 && !results.significant,
        "bad pair result carries counts or flags")
    `MPCC_ASSERT_IMP(a_no_accept_mid_rmw, item_acc,
        !v1_reg && state_reg == ST_IDLE,
        "request accepted while a counter write-back is pending")
    `MPCC_ASSERT_IMP(a_rmw_in_row, v1_reg,
        wr_addr_reg >= base_reg && wr_addr_reg < base_reg + AW'(p_reg),
        "write-back outside the current position row")

endmodule
`default_nettype wire
